/* hdl/occ_pkg.sv */
// Package for the occupancy / stillness alert block.
// Holds field widths, phase and alert codes, and the structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package occ_pkg;

  // Field widths
  localparam int unsigned ELAPSED_W   = 16;
  localparam int unsigned COUNTDOWN_W = 15;
  localparam int unsigned WINDOW_W    = 27;
  localparam int unsigned NEXT_W      = 31;
  localparam int unsigned STATE_W     = 2;
  localparam int unsigned ALERT_W     = 2;

  // APB-style configuration port
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register indexes (byte address = 4 * index)
  localparam logic [CFG_IDX_W-1:0] REG_COUNTDOWN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STILLNESS = 2'd2;

  // Register reset values
  localparam logic [COUNTDOWN_W-1:0] COUNTDOWN_RST = 15'd15000;
  localparam logic [WINDOW_W-1:0]    DURATION_RST  = 27'd30000;
  localparam logic [WINDOW_W-1:0]    STILLNESS_RST = 27'd15000;

  // Reported time to next deadline
  localparam logic [NEXT_W-1:0] NEXT_IDLE   = 31'h7FFF_FFFF;
  localparam logic [NEXT_W-1:0] NEXT_RETURN = 31'd1;

  // Encoded phase as reported on the result channel
  localparam logic [STATE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [STATE_W-1:0] PH_COUNT = 2'd1;
  localparam logic [STATE_W-1:0] PH_DUR   = 2'd2;
  localparam logic [STATE_W-1:0] PH_STILL = 2'd3;

  // Alert codes
  localparam logic [ALERT_W-1:0] ALERT_NONE  = 2'd0;
  localparam logic [ALERT_W-1:0] ALERT_DUR   = 2'd1;
  localparam logic [ALERT_W-1:0] ALERT_STILL = 2'd2;

  // Internal one-hot phase
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_COUNT = 4'b0010,
    ST_DUR   = 4'b0100,
    ST_STILL = 4'b1000
  } phase_t;

  // Live configuration values
  typedef struct packed {
    logic [COUNTDOWN_W-1:0] countdown_ms;
    logic [WINDOW_W-1:0]    duration_ms;
    logic [WINDOW_W-1:0]    stillness_ms;
  } cfg_t;

  // One sensor sample
  typedef struct packed {
    logic                 door_open;
    logic                 motion;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } sample_t;

  // One result
  typedef struct packed {
    logic [STATE_W-1:0] fsm_state;
    logic [ALERT_W-1:0] alert;
    logic [NEXT_W-1:0]  next_check_ms;
  } result_t;

endpackage

/* hdl/occ_ifs.sv */
// Valid/ready channel interfaces for sensor samples and results.
// Depends on occ_pkg for field widths.
`timescale 1ns / 1ps

interface occ_in_if;
  import occ_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 door_open;
  logic                 motion;
  logic [ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, door_open, motion, elapsed_ms, input ready);
  modport sink   (input valid, door_open, motion, elapsed_ms, output ready);
endinterface

interface occ_out_if;
  import occ_pkg::*;

  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] fsm_state;
  logic [ALERT_W-1:0] alert;
  logic [NEXT_W-1:0]  next_check_ms;

  modport source (output valid, fsm_state, alert, next_check_ms, input ready);
  modport sink   (input valid, fsm_state, alert, next_check_ms, output ready);
endinterface

/* hdl/occ_cfg_regs.sv */
// APB-style configuration registers with range checks on write.
// Depends on occ_pkg.
`timescale 1ns / 1ps

module occ_cfg_regs #(
  parameter int unsigned MAX_WINDOW_MS    = 86400000,
  parameter int unsigned MAX_COUNTDOWN_MS = 20000
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [occ_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [occ_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [occ_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output occ_pkg::cfg_t                    cfg
);
  import occ_pkg::*;

  logic [COUNTDOWN_W-1:0] countdown_r, countdown_nxt;
  logic [WINDOW_W-1:0]    duration_r, duration_nxt;
  logic [WINDOW_W-1:0]    stillness_r, stillness_nxt;
  logic                   wr_en;
  logic [CFG_IDX_W-1:0]   idx;
  logic [COUNTDOWN_W-1:0] wd_cd;
  logic [WINDOW_W-1:0]    wd_win;
  logic                   cd_ok;
  logic                   win_ok;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wd_cd  = pwdata[COUNTDOWN_W-1:0];
  assign wd_win = pwdata[WINDOW_W-1:0];

  // Writes whose field value is above the limit are dropped; data bits above the field are ignored
  assign cd_ok  = {{(32-COUNTDOWN_W){1'b0}}, wd_cd} <= 32'(MAX_COUNTDOWN_MS);
  assign win_ok = {{(32-WINDOW_W){1'b0}}, wd_win} <= 32'(MAX_WINDOW_MS);

  // Next-value decode
  always_comb begin
    countdown_nxt = countdown_r;
    duration_nxt  = duration_r;
    stillness_nxt = stillness_r;
    if (wr_en) begin
      unique case (idx)
        REG_COUNTDOWN: if (cd_ok) countdown_nxt = wd_cd;
        REG_DURATION:  if (win_ok) duration_nxt = wd_win;
        REG_STILLNESS: if (win_ok) stillness_nxt = wd_win;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= COUNTDOWN_RST;
      duration_r  <= DURATION_RST;
      stillness_r <= STILLNESS_RST;
    end else begin
      countdown_r <= countdown_nxt;
      duration_r  <= duration_nxt;
      stillness_r <= stillness_nxt;
    end
  end

  // Read-back mux
  always_comb begin
    unique case (idx)
      REG_COUNTDOWN: prdata = {{(CFG_DATA_W-COUNTDOWN_W){1'b0}}, countdown_r};
      REG_DURATION:  prdata = {{(CFG_DATA_W-WINDOW_W){1'b0}}, duration_r};
      REG_STILLNESS: prdata = {{(CFG_DATA_W-WINDOW_W){1'b0}}, stillness_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.countdown_ms = countdown_r;
  assign cfg.duration_ms  = duration_r;
  assign cfg.stillness_ms = stillness_r;

endmodule

/* hdl/occ_fsm_core.sv */
// Phase machine and remaining-time counters; computes one result per step.
// Depends on occ_pkg.
`timescale 1ns / 1ps

module occ_fsm_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  occ_pkg::sample_t smp,
  input  occ_pkg::cfg_t    cfg,
  output occ_pkg::result_t res
);
  import occ_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [COUNTDOWN_W-1:0] cd_left_r, cd_left_nxt;
  logic [WINDOW_W-1:0]    dur_left_r, dur_left_nxt;
  logic [WINDOW_W-1:0]    still_left_r, still_left_nxt;

  logic [COUNTDOWN_W-1:0] cd_dec;
  logic [WINDOW_W-1:0]    dur_dec;
  logic [WINDOW_W-1:0]    still_dec;
  logic [WINDOW_W-1:0]    el_w;
  logic [WINDOW_W-1:0]    still_min;
  logic [WINDOW_W-1:0]    stillness_min_entry;

  // Saturating countdowns by the elapsed time
  assign el_w      = {{(WINDOW_W-ELAPSED_W){1'b0}}, smp.elapsed_ms};
  assign cd_dec    = ({1'b0, cd_left_r} > smp.elapsed_ms)
                     ? COUNTDOWN_W'({1'b0, cd_left_r} - smp.elapsed_ms) : '0;
  assign dur_dec   = (dur_left_r > el_w) ? (dur_left_r - el_w) : '0;
  assign still_dec = (still_left_r > el_w) ? (still_left_r - el_w) : '0;

  // Nearest deadline in stillness, and on entering it
  assign still_min           = (still_dec < dur_dec) ? still_dec : dur_dec;
  assign stillness_min_entry = (cfg.stillness_ms < dur_dec) ? cfg.stillness_ms : dur_dec;

  // Transition and result logic
  always_comb begin
    phase_nxt          = phase_r;
    cd_left_nxt        = cd_left_r;
    dur_left_nxt       = dur_left_r;
    still_left_nxt     = still_left_r;
    res.alert          = ALERT_NONE;
    res.next_check_ms  = NEXT_IDLE;
    unique case (phase_r)
      ST_COUNT: begin
        cd_left_nxt = cd_dec;
        if (!smp.motion || smp.door_open) begin
          phase_nxt         = ST_IDLE;
          res.next_check_ms = NEXT_RETURN;
        end else if (cd_dec == '0) begin
          phase_nxt         = ST_DUR;
          dur_left_nxt      = cfg.duration_ms;
          res.next_check_ms = NEXT_W'(cfg.duration_ms);
        end else begin
          res.next_check_ms = NEXT_W'(cd_dec);
        end
      end
      ST_DUR: begin
        dur_left_nxt = dur_dec;
        if (!smp.motion) begin
          phase_nxt         = ST_STILL;
          still_left_nxt    = cfg.stillness_ms;
          res.next_check_ms = NEXT_W'(stillness_min_entry);
        end else if (dur_dec == '0) begin
          phase_nxt         = ST_IDLE;
          res.alert         = ALERT_DUR;
          res.next_check_ms = NEXT_RETURN;
        end else if (smp.door_open) begin
          phase_nxt         = ST_IDLE;
          res.next_check_ms = NEXT_RETURN;
        end else begin
          res.next_check_ms = NEXT_W'(dur_dec);
        end
      end
      ST_STILL: begin
        dur_left_nxt   = dur_dec;
        still_left_nxt = still_dec;
        // Stillness wins when both deadlines fall due
        if (smp.motion) begin
          phase_nxt         = ST_DUR;
          res.next_check_ms = NEXT_W'(dur_dec);
        end else if (still_dec == '0) begin
          phase_nxt         = ST_IDLE;
          res.alert         = ALERT_STILL;
          res.next_check_ms = NEXT_RETURN;
        end else if (dur_dec == '0) begin
          phase_nxt         = ST_IDLE;
          res.alert         = ALERT_DUR;
          res.next_check_ms = NEXT_RETURN;
        end else if (smp.door_open) begin
          phase_nxt         = ST_IDLE;
          res.next_check_ms = NEXT_RETURN;
        end else begin
          res.next_check_ms = NEXT_W'(still_min);
        end
      end
      default: begin
        // Idle: elapsed time is ignored
        if (smp.motion && !smp.door_open) begin
          phase_nxt         = ST_COUNT;
          cd_left_nxt       = cfg.countdown_ms;
          res.next_check_ms = NEXT_W'(cfg.countdown_ms);
        end
      end
    endcase

    // Encode the new phase for the result
    unique case (phase_nxt)
      ST_COUNT: res.fsm_state = PH_COUNT;
      ST_DUR:   res.fsm_state = PH_DUR;
      ST_STILL: res.fsm_state = PH_STILL;
      default:  res.fsm_state = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ST_IDLE;
      cd_left_r    <= '0;
      dur_left_r   <= '0;
      still_left_r <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      cd_left_r    <= cd_left_nxt;
      dur_left_r   <= dur_left_nxt;
      still_left_r <= still_left_nxt;
    end
  end

endmodule

/* hdl/occupancy_stillness_alert_fsm_top.sv */
// Occupancy / stillness alert block: sample register, phase core, result register.
// A sample is held in the sample register; its result then goes to the result register.
// Throughput: one sample per cycle unless the output stalls; the phase core updates in
// the same cycle that loads the result register, so back-to-back samples see the new phase.
// Reset: synchronous active-low; phase idle, counters zero, registers at defaults.
// Depends on occ_pkg, occ_ifs, occ_cfg_regs, occ_fsm_core.
`timescale 1ns / 1ps

module occupancy_stillness_alert_fsm_top #(
  parameter int unsigned MAX_WINDOW_MS    = 86400000,
  parameter int unsigned MAX_COUNTDOWN_MS = 20000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  occ_in_if.sink                         in_ch,
  occ_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [occ_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [occ_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [occ_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import occ_pkg::*;

  cfg_t    cfg;
  sample_t smp_r;
  logic    smp_vld_r, smp_vld_nxt;
  result_t res;
  result_t res_r;
  logic    res_vld_r, res_vld_nxt;
  logic    advance;
  logic    step;

  occ_cfg_regs #(
    .MAX_WINDOW_MS    (MAX_WINDOW_MS),
    .MAX_COUNTDOWN_MS (MAX_COUNTDOWN_MS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: result slot free or being drained
  assign advance     = !res_vld_r || out_ch.ready;
  assign step        = smp_vld_r && advance;
  assign in_ch.ready = !smp_vld_r || advance;

  assign smp_vld_nxt = in_ch.ready ? in_ch.valid : smp_vld_r;
  assign res_vld_nxt = step ? 1'b1 : (out_ch.ready ? 1'b0 : res_vld_r);

  // Sample register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
    end else begin
      smp_vld_r <= smp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      smp_r.door_open  <= in_ch.door_open;
      smp_r.motion     <= in_ch.motion;
      smp_r.elapsed_ms <= in_ch.elapsed_ms;
    end
  end

  occ_fsm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .smp   (smp_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = res_vld_r;
  assign out_ch.fsm_state     = res_r.fsm_state;
  assign out_ch.alert         = res_r.alert;
  assign out_ch.next_check_ms = res_r.next_check_ms;

endmodule

/* hdl/occ_checker.sv */
// Port-level checks on the result channel of the alert block, plus its bind.
// Depends on occ_pkg and occupancy_stillness_alert_fsm_top.
`timescale 1ns / 1ps

module occ_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [occ_pkg::STATE_W-1:0] out_fsm_state,
  input logic [occ_pkg::ALERT_W-1:0] out_alert,
  input logic [occ_pkg::NEXT_W-1:0]  out_next_check_ms
);
  import occ_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Nothing offered right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Any alert ends the session
  a_alert_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alert != ALERT_NONE |->
      out_fsm_state == PH_IDLE && out_next_check_ms == NEXT_RETURN)
    else $error("alert without return to idle");

  // Idle reports either the return mark or the idle maximum
  a_idle_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fsm_state == PH_IDLE |->
      out_next_check_ms == NEXT_RETURN || out_next_check_ms == NEXT_IDLE)
    else $error("bad next check in idle");

endmodule

bind occupancy_stillness_alert_fsm_top occ_checker u_occ_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_fsm_state     (out_ch.fsm_state),
  .out_alert         (out_ch.alert),
  .out_next_check_ms (out_ch.next_check_ms)
);
